FILE: sv/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and codes for the decimating complex FIR filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcf_pkg;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int TCNT_REG_W  = 10;
  localparam int DEC_REG_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX    = 2'd2;

  // Input word commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } dcf_state_t;

  // One tap step issued to the datapath
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic blank;
  } dcf_step_t;

endpackage

FILE: sv/dcf_in_if.sv
// ----------------------------------------------------------------------------
// dcf_in_if
// Input channel: coefficient loads and sample pushes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcf_in_if #(
  parameter int IDX_W  = 9,
  parameter int TAP_W  = 18,
  parameter int SAMP_W = 16
);
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [IDX_W-1:0]         tap_index;
  logic signed [TAP_W-1:0]  tap_value;
  logic signed [SAMP_W-1:0] sample_i;
  logic signed [SAMP_W-1:0] sample_q;

  modport source (
    output valid, command, tap_index, tap_value, sample_i, sample_q,
    input  ready
  );
  modport sink (
    input  valid, command, tap_index, tap_value, sample_i, sample_q,
    output ready
  );
endinterface

FILE: sv/dcf_out_if.sv
// ----------------------------------------------------------------------------
// dcf_out_if
// Output channel: filtered I/Q words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcf_out_if #(
  parameter int SAMP_W = 16
);
  logic                     valid;
  logic                     ready;
  logic signed [SAMP_W-1:0] out_i;
  logic signed [SAMP_W-1:0] out_q;

  modport source (
    output valid, out_i, out_q,
    input  ready
  );
  modport sink (
    input  valid, out_i, out_q,
    output ready
  );
endinterface

FILE: sv/dcf_store.sv
// ----------------------------------------------------------------------------
// dcf_store
// Tap memory and I/Q history memory, one write and one registered read each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcf_store #(
  parameter int MAX_TAPS       = 512,
  parameter int MAX_DECIMATION = 8,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int TAP_WIDTH      = 18
) (
  input  logic                           clk,
  input  logic                           tap_we,
  input  logic [$clog2(MAX_TAPS)-1:0]    tap_wr_addr,
  input  logic [TAP_WIDTH-1:0]           tap_wr_data,
  input  logic                           hist_we,
  input  logic [$clog2(MAX_TAPS*MAX_DECIMATION)-1:0] hist_wr_addr,
  input  logic [SAMPLE_WIDTH-1:0]        hist_wr_i,
  input  logic [SAMPLE_WIDTH-1:0]        hist_wr_q,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_TAPS)-1:0]    tap_rd_addr,
  input  logic [$clog2(MAX_TAPS*MAX_DECIMATION)-1:0] hist_rd_addr,
  output logic [TAP_WIDTH-1:0]           tap_rd,
  output logic [SAMPLE_WIDTH-1:0]        hist_rd_i,
  output logic [SAMPLE_WIDTH-1:0]        hist_rd_q
);

  localparam int DEPTH = MAX_TAPS * MAX_DECIMATION;

  logic [TAP_WIDTH-1:0]        tap_mem  [MAX_TAPS];
  logic [2*SAMPLE_WIDTH-1:0]   hist_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_wr_addr] <= tap_wr_data;
    end
    if (rd_en) begin
      tap_rd <= tap_mem[tap_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wr_addr] <= {hist_wr_q, hist_wr_i};
    end
    if (rd_en) begin
      {hist_rd_q, hist_rd_i} <= hist_mem[hist_rd_addr];
    end
  end

endmodule

FILE: sv/dcf_ctrl.sv
// ----------------------------------------------------------------------------
// dcf_ctrl
// Sequencer: write pointer, fill count, decimation phase and tap walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcf_ctrl import dcf_pkg::*; #(
  parameter int MAX_TAPS       = 512,
  parameter int MAX_DECIMATION = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  logic                         command,
  input  logic [$clog2(MAX_TAPS)-1:0]  tap_index,
  input  logic [TCNT_REG_W-1:0]        tap_count,
  input  logic [DEC_REG_W-1:0]         decimation_factor,
  input  logic                         take,
  output logic                         in_ready,
  output logic                         tap_we,
  output logic                         hist_we,
  output logic [$clog2(MAX_TAPS*MAX_DECIMATION)-1:0] hist_wr_addr,
  output logic [$clog2(MAX_TAPS)-1:0]  tap_rd_addr,
  output logic [$clog2(MAX_TAPS*MAX_DECIMATION)-1:0] hist_rd_addr,
  output dcf_step_t                    step
);

  localparam int DEPTH  = MAX_TAPS * MAX_DECIMATION;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int TI_W   = $clog2(MAX_TAPS);
  localparam int TAPS_W = $clog2(MAX_TAPS + 1);
  localparam int DEC_W  = $clog2(MAX_DECIMATION + 1);
  localparam int PH_W   = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
  localparam int TC_W   = (TCNT_REG_W > TAPS_W) ? TCNT_REG_W : TAPS_W;
  localparam int DC_W   = (DEC_REG_W > DEC_W) ? DEC_REG_W : DEC_W;

  dcf_state_t state, state_next;

  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W:0]    fill;
  logic [PH_W-1:0]   phase;
  logic [TI_W-1:0]   tap_idx;
  logic [PTR_W-1:0]  rd_pos;
  logic [PTR_W:0]    back;
  logic              first;

  logic [TC_W-1:0]   taps_wide;
  logic [DC_W-1:0]   dec_wide;
  logic [TAPS_W-1:0] taps_eff;
  logic [DEC_W-1:0]  dec_eff;
  logic [DEC_W-1:0]  phase_inc;
  logic              sample_fire;
  logic              emit;
  logic [PTR_W:0]    pos_wide;
  logic [PTR_W:0]    dec_step;
  logic [PTR_W:0]    pos_sub;
  logic [PTR_W-1:0]  pos_next;

  // Clamp the registers into their usable ranges
  always_comb begin
    taps_wide = TC_W'(tap_count);
    dec_wide  = DC_W'(decimation_factor);
    if (taps_wide == '0) begin
      taps_eff = TAPS_W'(1);
    end else if (taps_wide > TC_W'(MAX_TAPS)) begin
      taps_eff = TAPS_W'(MAX_TAPS);
    end else begin
      taps_eff = TAPS_W'(taps_wide);
    end
    if (dec_wide == '0) begin
      dec_eff = DEC_W'(1);
    end else if (dec_wide > DC_W'(MAX_DECIMATION)) begin
      dec_eff = DEC_W'(MAX_DECIMATION);
    end else begin
      dec_eff = DEC_W'(dec_wide);
    end
  end

  assign sample_fire = in_fire && (command == CMD_SAMPLE);
  assign phase_inc   = DEC_W'(phase) + DEC_W'(1);
  assign emit        = (phase_inc >= dec_eff);

  // Step back one tap spacing through the circular history
  assign pos_wide = {1'b0, rd_pos};
  assign dec_step = (PTR_W+1)'(dec_eff);
  assign pos_sub  = pos_wide - dec_step;
  assign pos_next = (pos_wide < dec_step) ? PTR_W'(pos_sub + (PTR_W+1)'(DEPTH))
                                          : PTR_W'(pos_sub);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_fire && emit) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_idx == '0) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE) && !rst;
    step.valid = (state == ST_RUN);
    step.first = first;
    step.last  = (tap_idx == '0);
    step.blank = (back >= fill);
  end

  assign tap_we       = in_fire && (command == CMD_LOAD) &&
                        (32'(tap_index) < MAX_TAPS);
  assign hist_we      = sample_fire;
  assign hist_wr_addr = wr_ptr;
  assign tap_rd_addr  = tap_idx;
  assign hist_rd_addr = rd_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wr_ptr  <= '0;
      fill    <= '0;
      phase   <= '0;
      tap_idx <= '0;
      rd_pos  <= '0;
      back    <= '0;
      first   <= 1'b0;
    end else begin
      state <= state_next;
      if (sample_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
        if (fill != (PTR_W+1)'(DEPTH)) begin
          fill <= fill + (PTR_W+1)'(1);
        end
        phase <= emit ? '0 : PH_W'(phase_inc);
        if (emit) begin
          tap_idx <= TI_W'(taps_eff - TAPS_W'(1));
          rd_pos  <= wr_ptr;
          back    <= '0;
          first   <= 1'b1;
        end
      end else if (state == ST_RUN) begin
        tap_idx <= tap_idx - TI_W'(1);
        rd_pos  <= pos_next;
        back    <= back + dec_step;
        first   <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/dcf_mac.sv
// ----------------------------------------------------------------------------
// dcf_mac
// Dual multiply-accumulate lanes with round and saturate to the sample width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcf_mac import dcf_pkg::*; #(
  parameter int MAX_TAPS     = 512,
  parameter int SAMPLE_WIDTH = 16,
  parameter int TAP_WIDTH    = 18
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dcf_step_t                       step,
  input  logic [TAP_WIDTH-1:0]            tap_rd,
  input  logic [SAMPLE_WIDTH-1:0]         hist_rd_i,
  input  logic [SAMPLE_WIDTH-1:0]         hist_rd_q,
  input  logic                            complex_mode,
  input  logic                            take,
  output logic                            done,
  output logic signed [SAMPLE_WIDTH-1:0]  res_i,
  output logic signed [SAMPLE_WIDTH-1:0]  res_q
);

  localparam int PW    = SAMPLE_WIDTH + TAP_WIDTH;
  localparam int ACC_W = PW + $clog2(MAX_TAPS);
  localparam int SH    = TAP_WIDTH - 2;

  localparam logic signed [ACC_W:0] RND = (ACC_W+1)'(1) << (SH - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  dcf_step_t               step_a;
  dcf_step_t               step_b;
  logic signed [PW-1:0]    prod_i;
  logic signed [PW-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc_i;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [SAMPLE_WIDTH-1:0] samp_i;
  logic signed [SAMPLE_WIDTH-1:0] samp_q;

  // Round half up, then clip to the signed sample range
  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W:0] r;
    logic signed [ACC_W:0] s;
    r = $signed({a[ACC_W-1], a}) + RND;
    s = r >>> SH;
    if (s > S_MAX) begin
      return S_MAX;
    end else if (s < S_MIN) begin
      return S_MIN;
    end else begin
      return s[SAMPLE_WIDTH-1:0];
    end
  endfunction

  // Entries never written since reset read as zero
  assign samp_i = step_a.blank ? '0 : $signed(hist_rd_i);
  assign samp_q = step_a.blank ? '0 : $signed(hist_rd_q);

  always_ff @(posedge clk) begin
    prod_i <= $signed(tap_rd) * samp_i;
    prod_q <= $signed(tap_rd) * samp_q;
    if (step_b.valid) begin
      acc_i <= step_b.first ? ACC_W'(prod_i) : acc_i + ACC_W'(prod_i);
      acc_q <= step_b.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_a <= '0;
      step_b <= '0;
      done   <= 1'b0;
    end else begin
      step_a <= step;
      step_b <= step_a;
      if (step_b.valid && step_b.last) begin
        done <= 1'b1;
      end else if (take) begin
        done <= 1'b0;
      end
    end
  end

  assign res_i = round_sat(acc_i);
  assign res_q = complex_mode ? round_sat(acc_q) : '0;

endmodule

FILE: sv/decimating_complex_fir_filter.sv
// ----------------------------------------------------------------------------
// decimating_complex_fir_filter
// Flow: a sample that completes a decimation period starts a walk over
//   taps entries (taps = tap_count after clamping); the input stays closed
//   until the result moves into the output register.
// Input: a coefficient load or a non-emitting sample leaves the input open;
//   the emitting sample closes it through the walk, set by the single
//   history read port, and while the output register stays full.
// Reset: synchronous; the history reads as zero through a fill count, so no
//   clearing pass is needed and the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimating_complex_fir_filter import dcf_pkg::*; #(
  parameter int MAX_TAPS       = 512,
  parameter int MAX_DECIMATION = 8,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int TAP_WIDTH      = 18
) (
  input  logic                   clk,
  input  logic                   rst,
  dcf_in_if.sink                 din,
  dcf_out_if.source              dout,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_TAPS * MAX_DECIMATION;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int TI_W  = $clog2(MAX_TAPS);

  // Configuration registers
  logic [TCNT_REG_W-1:0] tap_count;
  logic [DEC_REG_W-1:0]  decimation_factor;
  logic                  complex_mode;

  // Sequencer to memories and datapath
  logic                   in_fire;
  logic                   tap_we;
  logic                   hist_we;
  logic [PTR_W-1:0]       hist_wr_addr;
  logic [TI_W-1:0]        tap_rd_addr;
  logic [PTR_W-1:0]       hist_rd_addr;
  dcf_step_t              step;
  logic [TAP_WIDTH-1:0]   tap_rd;
  logic [SAMPLE_WIDTH-1:0] hist_rd_i;
  logic [SAMPLE_WIDTH-1:0] hist_rd_q;

  // Datapath result and output hand-off
  logic                           mac_done;
  logic signed [SAMPLE_WIDTH-1:0] res_i;
  logic signed [SAMPLE_WIDTH-1:0] res_q;
  logic                           take;

  // Registers are to be written only while the block is idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count         <= TCNT_REG_W'(1);
      decimation_factor <= DEC_REG_W'(1);
      complex_mode      <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TAP_COUNT:  tap_count         <= cfg_data[TCNT_REG_W-1:0];
        CFG_DECIMATION: decimation_factor <= cfg_data[DEC_REG_W-1:0];
        CFG_COMPLEX:    complex_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_fire = din.valid && din.ready;

  // Sequencer: accept words, write history, walk taps for each output
  dcf_ctrl #(
    .MAX_TAPS       (MAX_TAPS),
    .MAX_DECIMATION (MAX_DECIMATION)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_fire           (in_fire),
    .command           (din.command),
    .tap_index         (din.tap_index),
    .tap_count         (tap_count),
    .decimation_factor (decimation_factor),
    .take              (take),
    .in_ready          (din.ready),
    .tap_we            (tap_we),
    .hist_we           (hist_we),
    .hist_wr_addr      (hist_wr_addr),
    .tap_rd_addr       (tap_rd_addr),
    .hist_rd_addr      (hist_rd_addr),
    .step              (step)
  );

  // Tap and history memories; read data is registered and arrives in the cycle after the step
  dcf_store #(
    .MAX_TAPS       (MAX_TAPS),
    .MAX_DECIMATION (MAX_DECIMATION),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .TAP_WIDTH      (TAP_WIDTH)
  ) u_store (
    .clk          (clk),
    .tap_we       (tap_we),
    .tap_wr_addr  (din.tap_index),
    .tap_wr_data  (din.tap_value),
    .hist_we      (hist_we),
    .hist_wr_addr (hist_wr_addr),
    .hist_wr_i    (din.sample_i),
    .hist_wr_q    (din.sample_q),
    .rd_en        (step.valid),
    .tap_rd_addr  (tap_rd_addr),
    .hist_rd_addr (hist_rd_addr),
    .tap_rd       (tap_rd),
    .hist_rd_i    (hist_rd_i),
    .hist_rd_q    (hist_rd_q)
  );

  // Multiply, accumulate, then round and saturate
  dcf_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TAP_WIDTH    (TAP_WIDTH)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .tap_rd       (tap_rd),
    .hist_rd_i    (hist_rd_i),
    .hist_rd_q    (hist_rd_q),
    .complex_mode (complex_mode),
    .take         (take),
    .done         (mac_done),
    .res_i        (res_i),
    .res_q        (res_q)
  );

  // Output register: move the result over once the slot frees up, and
  // hold it until the sink takes the word.
  assign take = mac_done && (!dout.valid || dout.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (take) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dout.out_i <= res_i;
      dout.out_q <= res_q;
    end
  end

  // A held result in the datapath keeps the input closed
  a_done_blocks_input: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> !din.ready)
    else $error("input open while a result waits in the datapath");

  // No tap or history write while the tap walk reads the memories
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    step.valid |-> !hist_we && !tap_we)
    else $error("memory write during tap walk");

  // No new tap step while a finished sum still waits for hand-off
  a_no_step_when_done: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> !step.valid)
    else $error("tap step issued over a pending result");

endmodule
